### rtl/sktl_pkg.sv
// Package: shared types and constants of the sorted key table.
`timescale 1ns / 1ps

package sktl_pkg;

  // Field widths of one item
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ACCESS_W = 8;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ENTRY_W  = KEY_W + VALUE_W + ACCESS_W;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SET    = 2'd2
  } cmd_e;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    logic [ACCESS_W-1:0]       access;
  } entry_t;

  // One result item
  typedef struct packed {
    logic                      ok;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic [ACCESS_W-1:0]       access;
  } result_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PROBE = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_INS   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

### rtl/sktl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sktl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/sktl_seq.sv
// Sequencer: binary search with one shared compare unit, entry shift and result capture.
`timescale 1ns / 1ps

module sktl_seq #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command side
  input  logic                               start_i,
  input  logic [sktl_pkg::CMD_W-1:0]         cmd_i,
  input  logic [sktl_pkg::KEY_W-1:0]         key_i,
  input  logic signed [sktl_pkg::VALUE_W-1:0] val_i,
  input  logic [sktl_pkg::ACCESS_W-1:0]      acc_i,
  output logic                               busy_o,
  // result side
  output logic                               res_valid_o,
  input  logic                               res_take_i,
  output sktl_pkg::result_t                  res_o,
  // table memory
  output logic                               ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     ram_waddr_o,
  output sktl_pkg::entry_t                   ram_wdata_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     ram_raddr_o,
  input  sktl_pkg::entry_t                   ram_rdata_i
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  sktl_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [IW-1:0] rp_q, rp_d;
  logic [IW-1:0] wa_q, wa_d;
  logic          pend_q, pend_d;

  logic [sktl_pkg::CMD_W-1:0]          cmd_q, cmd_d;
  logic [sktl_pkg::KEY_W-1:0]          key_q, key_d;
  logic signed [sktl_pkg::VALUE_W-1:0] val_q, val_d;
  logic [sktl_pkg::ACCESS_W-1:0]       acc_q, acc_d;
  sktl_pkg::result_t                   res_q, res_d;

  logic [CW-1:0] mid_full;
  logic [IW-1:0] pos;
  logic          key_eq;
  logic          key_lt;
  logic          key_le;
  logic          is_insert;
  logic          is_set;

  // Shared probe unit: midpoint of the half-open range and key compare
  assign mid_full  = lo_q + ((hi_q - CW'(1) - lo_q) >> 1);
  assign pos       = lo_q[IW-1:0];
  assign key_eq    = (ram_rdata_i.key == key_q);
  assign key_lt    = (ram_rdata_i.key < key_q);
  assign key_le    = key_eq | key_lt;
  assign is_insert = (cmd_q == sktl_pkg::CMD_INSERT);
  assign is_set    = (cmd_q == sktl_pkg::CMD_SET);

  assign busy_o      = (state_q != sktl_pkg::S_IDLE);
  assign res_valid_o = (state_q == sktl_pkg::S_DONE);
  assign res_o       = res_q;

  // Next state, search bounds, shift pointers and memory port
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    rp_d        = rp_q;
    wa_d        = wa_q;
    pend_d      = pend_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    acc_d       = acc_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = mid_full[IW-1:0];

    unique case (state_q)
      sktl_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          key_d = key_i;
          val_d = val_i;
          acc_d = acc_i;
          lo_d  = '0;
          hi_d  = count_q;
          res_d = '0;
          case (cmd_i)
            sktl_pkg::CMD_INSERT: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                state_d = sktl_pkg::S_DONE;
              end else begin
                state_d = sktl_pkg::S_PROBE;
              end
            end
            sktl_pkg::CMD_LOOKUP, sktl_pkg::CMD_SET: begin
              state_d = sktl_pkg::S_PROBE;
            end
            default: begin
              state_d = sktl_pkg::S_DONE;
            end
          endcase
        end
      end

      sktl_pkg::S_PROBE: begin
        if (lo_q < hi_q) begin
          // issue read of the midpoint
          mid_d   = mid_full[IW-1:0];
          state_d = sktl_pkg::S_CMP;
        end else if (is_insert) begin
          // insert position found: shift the tail up when there is one
          rp_d   = IW'(count_q - CW'(1));
          pend_d = 1'b0;
          if (lo_q == count_q) begin
            state_d = sktl_pkg::S_INS;
          end else begin
            state_d = sktl_pkg::S_SHIFT;
          end
        end else begin
          // miss
          res_d   = '0;
          state_d = sktl_pkg::S_DONE;
        end
      end

      sktl_pkg::S_CMP: begin
        if (is_insert) begin
          // upper bound: first entry whose key is greater
          if (key_le) begin
            lo_d = CW'(mid_q) + CW'(1);
          end else begin
            hi_d = CW'(mid_q);
          end
          state_d = sktl_pkg::S_PROBE;
        end else if (key_eq) begin
          res_d.ok     = 1'b1;
          res_d.slot   = sktl_pkg::SLOT_W'(mid_q);
          res_d.access = ram_rdata_i.access;
          if (is_set) begin
            ram_we_o          = 1'b1;
            ram_waddr_o       = mid_q;
            ram_wdata_o.value = val_q;
            res_d.value       = val_q;
          end else begin
            res_d.value = ram_rdata_i.value;
          end
          state_d = sktl_pkg::S_DONE;
        end else begin
          if (key_lt) begin
            lo_d = CW'(mid_q) + CW'(1);
          end else begin
            hi_d = CW'(mid_q);
          end
          state_d = sktl_pkg::S_PROBE;
        end
      end

      sktl_pkg::S_SHIFT: begin
        // read entry rp, write the previously read entry one place up
        ram_raddr_o = rp_q;
        ram_we_o    = pend_q;
        pend_d      = 1'b1;
        wa_d        = rp_q + IW'(1);
        if (rp_q == pos) begin
          state_d = sktl_pkg::S_DRAIN;
        end else begin
          rp_d = rp_q - IW'(1);
        end
      end

      sktl_pkg::S_DRAIN: begin
        // write the last shifted entry
        ram_we_o = 1'b1;
        state_d  = sktl_pkg::S_INS;
      end

      sktl_pkg::S_INS: begin
        // place the new entry
        ram_we_o           = 1'b1;
        ram_waddr_o        = pos;
        ram_wdata_o.key    = key_q;
        ram_wdata_o.value  = val_q;
        ram_wdata_o.access = acc_q;
        count_d            = count_q + CW'(1);
        res_d              = '0;
        res_d.ok           = 1'b1;
        res_d.slot         = sktl_pkg::SLOT_W'(pos);
        state_d            = sktl_pkg::S_DONE;
      end

      sktl_pkg::S_DONE: begin
        // hold the result until the output register takes it
        if (res_take_i) begin
          state_d = sktl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sktl_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sktl_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers and pending result
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    rp_q  <= rp_d;
    wa_q  <= wa_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    val_q <= val_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

endmodule

### rtl/sorted_key_table_lookup_insert_core.sv
// Top level: sorted key table with insert, lookup and set commands.
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | cmd_i, key_i, data_value_i, access_code_i
//  out     | output    | out_valid_o/out_stall_i | ok_o, slot_o, read_value_o, read_access_o
//
//  Lookup and set binary-search the n stored entries, stopping early on a hit: every probe
//  of the binary search is one read of the table memory and one compare. Insert adds a
//  shift of the n - slot later entries at one entry per cycle through the single write port;
//  the drain state writes the last shifted entry and the insert state places the new entry
//  (it alone for an entry at the end). Reset clears the entry count only; no clearing
//  pass. The output register frees the block for the next item while a result waits.

module sorted_key_table_lookup_insert_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sktl_pkg::CMD_W-1:0]          cmd_i,
  input  logic [sktl_pkg::KEY_W-1:0]          key_i,
  input  logic signed [sktl_pkg::VALUE_W-1:0] data_value_i,
  input  logic [sktl_pkg::ACCESS_W-1:0]       access_code_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [sktl_pkg::SLOT_W-1:0]         slot_o,
  output logic signed [sktl_pkg::VALUE_W-1:0] read_value_o,
  output logic [sktl_pkg::ACCESS_W-1:0]       read_access_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  logic                  busy;
  logic                  res_valid;
  logic                  res_take;
  sktl_pkg::result_t     res;
  sktl_pkg::result_t     out_q;
  logic                  out_valid_q;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [IW-1:0]         ram_raddr;
  sktl_pkg::entry_t      ram_wdata;
  sktl_pkg::entry_t      ram_rdata;

  assign in_stall_o = busy;
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  sktl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .val_i       (data_value_i),
    .acc_i       (access_code_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sktl_ram #(
    .WIDTH (sktl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_q.ok;
  assign slot_o        = out_q.slot;
  assign read_value_o  = out_q.value;
  assign read_access_o = out_q.access;

endmodule
